// ----- rtl/cfmg_pkg.sv -----
// ----------------------------------------------------------------------------
// cfmg_pkg: shared types and constants of the CIDR first-match geo block
// Modes, status codes, the word that walks the cell chain and the mask helper.
// ----------------------------------------------------------------------------
package cfmg_pkg;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [1:0] MODE_BLOCK   = 2'd2;
  localparam logic [1:0] MODE_UNBLOCK = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MAP_FULL = 2'd1;
  localparam logic [1:0] ST_BLK_FULL = 2'd2;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CC_W   = 16;
  localparam int unsigned PLEN_W = 6;

  // word carried from cell to cell
  typedef struct packed {
    logic              vld;
    logic [1:0]        mode;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic [CC_W-1:0]   code;
    logic              found;
    logic [CC_W-1:0]   country;
    logic              blocked;
    logic              placed;   // a free block slot took the code
    logic              dup;      // code already in the block set
  } tok_t;

  // end-of-walk control broadcast to the block cells
  typedef struct packed {
    logic fin;
    logic keep;
  } blk_ctl_t;

  typedef struct packed {
    logic            found;
    logic [CC_W-1:0] country;
    logic            blocked;
    logic [1:0]      status;
  } res_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [PLEN_W-1:0] p;
    p = (plen > PLEN_W'(ADDR_W)) ? PLEN_W'(ADDR_W) : plen;
    return ~({ADDR_W{1'b1}} >> p);
  endfunction

endpackage

// ----- rtl/cfmg_map_cell.sv -----
// ----------------------------------------------------------------------------
// cfmg_map_cell: one prefix table entry
// Stores network, mask and country; appends on add, matches on lookup.
// ----------------------------------------------------------------------------
module cfmg_map_cell
  import cfmg_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] count_i,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic [ADDR_W-1:0] net_r;
  logic [ADDR_W-1:0] mask_r;
  logic [CC_W-1:0]   cc_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              hit;
  logic              wr;

  assign wr  = tok_i.vld && (tok_i.mode == MODE_ADD) && (count_i == CNT_W'(IDX));
  // entries at or above the fill count hold nothing yet
  assign hit = tok_i.vld && (tok_i.mode == MODE_LOOKUP) && !tok_i.found &&
               (CNT_W'(IDX) < count_i) && ((tok_i.addr & mask_r) == net_r);

  always_comb begin
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.country = cc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      net_r  <= tok_i.addr & tok_i.mask;
      mask_r <= tok_i.mask;
      cc_r   <= tok_i.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- rtl/cfmg_blk_cell.sv -----
// ----------------------------------------------------------------------------
// cfmg_blk_cell: one slot of the blocked-country set
// Checks membership, takes a new code tentatively, drops a code on unblock.
// ----------------------------------------------------------------------------
module cfmg_blk_cell
  import cfmg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  blk_ctl_t ctl_i,
  input  tok_t     tok_i,
  output tok_t     tok_o
);

  logic [CC_W-1:0] code_r;
  logic            valid_r;
  logic            pend_r;
  tok_t            tok_r;
  tok_t            tok_nxt;
  logic            take;
  logic            drop;

  assign take = tok_i.vld && (tok_i.mode == MODE_BLOCK) && !valid_r && !tok_i.placed;
  assign drop = tok_i.vld && (tok_i.mode == MODE_UNBLOCK) && valid_r &&
                (code_r == tok_i.code);

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.vld && (tok_i.mode == MODE_LOOKUP) && tok_i.found && valid_r &&
        (code_r == tok_i.country)) begin
      tok_nxt.blocked = 1'b1;
    end
    if (tok_i.vld && (tok_i.mode == MODE_BLOCK) && valid_r && (code_r == tok_i.code)) begin
      tok_nxt.dup = 1'b1;
    end
    if (take) begin
      tok_nxt.placed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_r <= tok_i.code;
    end
  end

  // a taken slot becomes live only if no duplicate turned up elsewhere in the set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      pend_r    <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (take) begin
        pend_r <= 1'b1;
      end else if (ctl_i.fin && pend_r) begin
        pend_r  <= 1'b0;
        valid_r <= ctl_i.keep;
      end else if (drop) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- rtl/cidr_first_match_geo_block.sv -----
// ----------------------------------------------------------------------------
// cidr_first_match_geo_block: IPv4 prefix table, first-match country lookup
// Words walk a chain of table cells, then a chain of block-set cells.
// ----------------------------------------------------------------------------
//  channel | ports                                              | dir
//  input   | in_valid in_stall in_mode in_address in_prefix_len | in
//          | in_country_code                                    |
//  result  | out_valid out_stall out_country_found              | out
//          | out_matched_country out_is_blocked out_status      |
//
//  One word at a time. A word passes one cell per cycle; its result is
//  registered at the output, or in the skid register, when it leaves the
//  last block cell, and the next word is taken once the FSM is idle again.
//  Reset: fill count and block slots cleared at once, no sweep.
//  A stalled result sits in a skid register; input stalls only while that
//  is also full or a word is in the chain.
// ----------------------------------------------------------------------------
module cidr_first_match_geo_block
  import cfmg_pkg::*;
#(
  parameter int unsigned MAP_DEPTH   = 64,
  parameter int unsigned BLOCK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [PLEN_W-1:0] in_prefix_len,
  input  logic [CC_W-1:0]   in_country_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_country_found,
  output logic [CC_W-1:0]   out_matched_country,
  output logic              out_is_blocked,
  output logic [1:0]        out_status
);

  localparam int unsigned CNT_W = $clog2(MAP_DEPTH + 1);

  typedef enum logic {S_IDLE, S_BUSY} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic             out_vld_r;
  res_t             out_res_r;
  logic             skid_vld_r;
  res_t             skid_res_r;

  tok_t     map_tok [MAP_DEPTH+1];
  tok_t     blk_tok [BLOCK_DEPTH+1];
  tok_t     ex;
  blk_ctl_t blk_ctl;
  res_t     res;
  logic     accept;
  logic     map_full;

  assign in_stall = (state_r != S_IDLE) || skid_vld_r;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    map_tok[0].vld     = accept;
    map_tok[0].mode    = in_mode;
    map_tok[0].addr    = in_address;
    map_tok[0].mask    = prefix_mask(in_prefix_len);
    map_tok[0].code    = in_country_code;
    map_tok[0].found   = 1'b0;
    map_tok[0].country = '0;
    map_tok[0].blocked = 1'b0;
    map_tok[0].placed  = 1'b0;
    map_tok[0].dup     = 1'b0;
  end

  for (genvar g = 0; g < MAP_DEPTH; g++) begin : g_map
    cfmg_map_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count_i (count_r),
      .tok_i   (map_tok[g]),
      .tok_o   (map_tok[g+1])
    );
  end

  assign blk_tok[0] = map_tok[MAP_DEPTH];

  for (genvar g = 0; g < BLOCK_DEPTH; g++) begin : g_blk
    cfmg_blk_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (blk_ctl),
      .tok_i (blk_tok[g]),
      .tok_o (blk_tok[g+1])
    );
  end

  assign ex           = blk_tok[BLOCK_DEPTH];
  assign blk_ctl.fin  = ex.vld;
  assign blk_ctl.keep = !ex.dup;
  assign map_full     = (count_r == CNT_W'(MAP_DEPTH));

  always_comb begin
    res.found   = ex.found;
    res.country = ex.country;
    res.blocked = ex.blocked;
    res.status  = ST_OK;
    case (ex.mode)
      MODE_ADD:   res.status = map_full ? ST_MAP_FULL : ST_OK;
      MODE_BLOCK: res.status = (!ex.dup && !ex.placed) ? ST_BLK_FULL : ST_OK;
      default:    res.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (ex.vld) begin
            state_r <= S_IDLE;
            if (ex.mode == MODE_ADD && !map_full) begin
              count_r <= count_r + CNT_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (ex.vld) begin
        if (out_vld_r && out_stall) begin
          skid_res_r <= res;
          skid_vld_r <= 1'b1;
        end else begin
          out_res_r <= res;
          out_vld_r <= 1'b1;
        end
      end else if (out_vld_r && !out_stall) begin
        if (skid_vld_r) begin
          out_res_r  <= skid_res_r;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid           = out_vld_r;
  assign out_country_found   = out_res_r.found;
  assign out_matched_country = out_res_r.country;
  assign out_is_blocked      = out_res_r.blocked;
  assign out_status          = out_res_r.status;

endmodule

// ----- rtl/cfmg_check.sv -----
// ----------------------------------------------------------------------------
// cfmg_check: port-level checks for the CIDR first-match geo block
// Watches result consistency and the one-word-at-a-time input behavior.
// ----------------------------------------------------------------------------
module cfmg_check
  import cfmg_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic            out_country_found,
  input logic [CC_W-1:0] out_matched_country,
  input logic            out_is_blocked,
  input logic [1:0]      out_status
);

  // no match or not a lookup: country and block flag are zero
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_country_found |-> out_matched_country == '0 && !out_is_blocked)
    else $error("result without match carries country or block flag");

  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_country_found |-> out_status == ST_OK)
    else $error("lookup result with nonzero status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_MAP_FULL ||
                  out_status == ST_BLK_FULL)
    else $error("undefined status code");

  // a word in the chain holds off the next one
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched_country) &&
                               $stable(out_status))
    else $error("stalled result changed");

endmodule

bind cidr_first_match_geo_block cfmg_check u_cfmg_check (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_country_found   (out_country_found),
  .out_matched_country (out_matched_country),
  .out_is_blocked      (out_is_blocked),
  .out_status          (out_status)
);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for cidr_first_match_geo_block
// Directed and random add, lookup, block and unblock words are driven into the
// block. A scoreboard keeps its own table and block set, and each result is
// checked in order against its prediction.
// ----------------------------------------------------------------------------
module tb;
  import cfmg_pkg::*;

  localparam int unsigned MAP_ENTRIES   = 64;
  localparam int unsigned BLOCK_ENTRIES = 16;
  localparam int unsigned RANDOM_WORDS  = 630;
  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned DRAIN_CYCLES  = 2 * (MAP_ENTRIES + BLOCK_ENTRIES);
  // receiver: one long hold-off, one window that never stalls
  localparam int unsigned HOLD_START   = 15000;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned STEADY_START = 30000;
  localparam int unsigned STEADY_END   = 37000;

  localparam logic [15:0] CC_POOL [24] = '{
    "US", "CN", "RU", "DE", "FR", "GB", "JP", "KR", "IN", "BR", "NL", "SE",
    "IR", "KP", "SY", "CU", "UA", "PL", "IT", "ES", "CA", "AU", "ZA", "MX"
  };

  class geo_scoreboard;
    logic [31:0] net_tab  [MAP_ENTRIES];
    logic [31:0] mask_tab [MAP_ENTRIES];
    logic [15:0] cc_tab   [MAP_ENTRIES];
    int unsigned n_entries;
    logic [15:0] blk_code [BLOCK_ENTRIES];
    bit          blk_used [BLOCK_ENTRIES];
    res_t        verdict_q [$];
    int unsigned errors;

    function new();
      n_entries = 0;
      errors    = 0;
      foreach (blk_used[i]) blk_used[i] = 1'b0;
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    function bit code_in_set(logic [15:0] code);
      foreach (blk_used[i])
        if (blk_used[i] && blk_code[i] == code) return 1'b1;
      return 1'b0;
    endfunction

    // accepted input word: update the shadow state, queue its result
    function void note_word(logic [1:0] mode, logic [31:0] addr, logic [5:0] plen,
                            logic [15:0] code);
      res_t        r;
      logic [5:0]  p;
      logic [31:0] m;
      bit          placed;
      r = '0;
      r.status = ST_OK;
      case (mode)
        MODE_ADD: begin
          if (n_entries >= MAP_ENTRIES) begin
            r.status = ST_MAP_FULL;
          end else begin
            p = (plen > 6'd32) ? 6'd32 : plen;
            m = (p == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - p));
            net_tab[n_entries]  = addr & m;
            mask_tab[n_entries] = m;
            cc_tab[n_entries]   = code;
            n_entries++;
          end
        end
        MODE_LOOKUP: begin
          // first entry in insertion order wins, not the longest prefix
          for (int i = 0; i < n_entries; i++) begin
            if ((addr & mask_tab[i]) == net_tab[i]) begin
              r.found   = 1'b1;
              r.country = cc_tab[i];
              r.blocked = code_in_set(cc_tab[i]);
              break;
            end
          end
        end
        MODE_BLOCK: begin
          if (!code_in_set(code)) begin
            placed = 1'b0;
            for (int i = 0; i < BLOCK_ENTRIES; i++) begin
              if (!blk_used[i]) begin
                blk_used[i] = 1'b1;
                blk_code[i] = code;
                placed = 1'b1;
                break;
              end
            end
            if (!placed) r.status = ST_BLK_FULL;
          end
        end
        default: begin
          foreach (blk_used[i])
            if (blk_used[i] && blk_code[i] == code) blk_used[i] = 1'b0;
        end
      endcase
      verdict_q = {verdict_q, r};
    endfunction

    function void check_word(logic found, logic [15:0] country, logic blocked,
                             logic [1:0] status);
      res_t want;
      res_t got;
      got = '{found: found, country: country, blocked: blocked, status: status};
      if (verdict_q.size() == 0) begin
        $display("%0t: result word with nothing pending:", $time);
        $display("%0t:          actual   found=%0b country=%h blocked=%0b status=%0d",
                 $time, found, country, blocked, status);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected found=%0b country=%h blocked=%0b status=%0d",
                 $time, want.found, want.country, want.blocked, want.status);
        $display("%0t:          actual   found=%0b country=%h blocked=%0b status=%0d",
                 $time, got.found, got.country, got.blocked, got.status);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_mode = MODE_LOOKUP;
  logic [ADDR_W-1:0] in_address = '0;
  logic [PLEN_W-1:0] in_prefix_len = '0;
  logic [CC_W-1:0]   in_country_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_country_found;
  logic [CC_W-1:0]   out_matched_country;
  logic              out_is_blocked;
  logic [1:0]        out_status;

  geo_scoreboard sb;
  logic [31:0] added_net  [$];
  logic [5:0]  added_plen [$];

  cidr_first_match_geo_block #(
    .MAP_DEPTH   (MAP_ENTRIES),
    .BLOCK_DEPTH (BLOCK_ENTRIES)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_address          (in_address),
    .in_prefix_len       (in_prefix_len),
    .in_country_code     (in_country_code),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_country_found   (out_country_found),
    .out_matched_country (out_matched_country),
    .out_is_blocked      (out_is_blocked),
    .out_status          (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(input logic [1:0] mode, input logic [31:0] addr,
                           input logic [5:0] plen, input logic [15:0] code);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_address      <= addr;
    in_prefix_len   <= plen;
    in_country_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(mode, addr, plen, code);
    if (mode == MODE_ADD) begin
      added_net  = {added_net, addr};
      added_plen = {added_plen, plen};
    end
  endtask

  task automatic idle_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  function automatic logic [15:0] any_country();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return CC_POOL[$urandom_range(0, 23)];
    if (r < 95) return 16'($urandom());
    return 16'h0000;
  endfunction

  // an address inside some network already added, random host bits
  function automatic logic [31:0] near_addr();
    int unsigned i;
    logic [31:0] host;
    if (added_net.size() == 0) return $urandom();
    i = $urandom_range(0, added_net.size() - 1);
    host = (added_plen[i] >= 6'd32) ? 32'h0 : (32'hFFFF_FFFF >> added_plen[i]);
    return (added_net[i] & ~host) | ($urandom() & host);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_country_found, out_matched_country, out_is_blocked, out_status);
  end

  initial begin : result_sink
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        out_stall <= 1'b1;
      end else if (cyc >= STEADY_START && cyc < STEADY_END) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 12);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned sel;
    int unsigned adds_sent;
    bit          blk_heavy;
    logic [5:0]  plen;
    sb = new();
    adds_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, masking, shadowing, saturation, block set cases
    send_word(MODE_LOOKUP,  32'h0A01_0203, 6'd0,  "US");
    send_word(MODE_ADD,     32'h0A12_3456, 6'd8,  "US");
    send_word(MODE_ADD,     32'h0A01_0000, 6'd16, "CN");  // shadowed by the /8
    send_word(MODE_ADD,     32'hFFFF_FFFF, 6'd32, "RU");
    send_word(MODE_ADD,     32'hC0A8_0101, 6'd63, 16'h0000);
    send_word(MODE_ADD,     32'hAC10_0000, 6'd12, 16'hFFFF);
    send_word(MODE_LOOKUP,  32'h0A01_0203, 6'd0,  16'h0000);
    send_word(MODE_LOOKUP,  32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    send_word(MODE_LOOKUP,  32'hC0A8_0101, 6'd0,  16'h0000);
    send_word(MODE_LOOKUP,  32'hC0A8_0100, 6'd0,  16'h0000);
    send_word(MODE_LOOKUP,  32'hAC1F_FFFF, 6'd0,  16'h0000);
    send_word(MODE_LOOKUP,  32'h0000_0000, 6'd0,  16'h0000);
    send_word(MODE_BLOCK,   32'h0000_0000, 6'd0,  "US");
    send_word(MODE_BLOCK,   32'hFFFF_FFFF, 6'd63, "US");
    send_word(MODE_LOOKUP,  32'h0A7F_0000, 6'd0,  16'h0000);
    send_word(MODE_BLOCK,   32'h0000_0000, 6'd0,  16'h0000);
    send_word(MODE_LOOKUP,  32'hC0A8_0101, 6'd0,  16'h0000);
    send_word(MODE_UNBLOCK, 32'h0000_0000, 6'd0,  "DE");
    send_word(MODE_UNBLOCK, 32'h0000_0000, 6'd0,  "US");
    send_word(MODE_LOOKUP,  32'h0AFF_FFFF, 6'd0,  16'h0000);
    send_word(MODE_UNBLOCK, 32'h0000_0000, 6'd0,  16'h0000);
    send_word(MODE_LOOKUP,  32'hC0A8_0101, 6'd0,  16'h0000);
    adds_sent = 5;

    // random: alternating block-heavy and unblock-heavy stretches
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(0, 99);
      blk_heavy = ((n / 100) % 2) == 0;
      if (sel < 8) begin
        send_word(2'($urandom()), $urandom(), 6'($urandom()), 16'($urandom()));
      end else if (sel < 30) begin
        // one catch-all entry late in the fill, shadowing everything after it
        if (adds_sent == 55) plen = 6'd0;
        else begin
          case ($urandom_range(0, 9))
            0:       plen = 6'($urandom_range(33, 63));
            1:       plen = 6'($urandom_range(1, 7));
            default: plen = 6'($urandom_range(8, 32));
          endcase
        end
        send_word(MODE_ADD, $urandom_range(0, 1) ? near_addr() : $urandom(), plen,
                  any_country());
        adds_sent++;
      end else if (sel < 70) begin
        send_word(MODE_LOOKUP, ($urandom_range(0, 3) != 0) ? near_addr() : $urandom(),
                  6'($urandom()), 16'($urandom()));
      end else if (sel < (blk_heavy ? 92 : 78)) begin
        send_word(MODE_BLOCK, $urandom(), 6'($urandom()), any_country());
      end else begin
        send_word(MODE_UNBLOCK, $urandom(), 6'($urandom()), any_country());
      end
      if (!(n >= 250 && n < 330) && $urandom_range(0, 99) < 12)
        idle_sender($urandom_range(1, 90));
    end
    idle_sender(1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
